// ----- design/lsh_pkg.sv -----
// Shared types and constants for the 3x3 Laplacian sharpening unit.
package lsh_pkg;

	localparam int PIX_W     = 8;
	localparam int CFG_W     = 11;
	localparam int OUT_IDX_W = 10;
	localparam int CFG_IDX_W = 1;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [CFG_W-1:0] cfg_data_t;
	typedef logic [OUT_IDX_W-1:0] out_idx_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// Window register control from the pipeline to the kernel
	typedef struct packed {
		logic advance;
		logic restart;
	} win_ctrl_t;

endpackage

// ----- design/lsh_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module lsh_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/lsh_scan.sv -----
// Raster scan counters and frame geometry registers.
module lsh_scan #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	localparam int CB = $clog2(MAX_WIDTH),
	localparam int RB = $clog2(MAX_HEIGHT)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lsh_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  lsh_pkg::cfg_data_t               cfg_data,
	input  logic                             step,
	output logic [CB-1:0]                    col,
	output logic [RB-1:0]                    row,
	output logic [CB-1:0]                    w_last,
	output logic [RB-1:0]                    h_last
);

	localparam int W_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
	localparam int H_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

	logic [CB-1:0] col_q;
	logic [RB-1:0] row_q;
	logic [CB-1:0] w_last_q;
	logic [RB-1:0] h_last_q;
	logic [CB-1:0] w_new;
	logic [RB-1:0] h_new;
	lsh_pkg::cfg_reg_t reg_sel;

	assign reg_sel = lsh_pkg::cfg_reg_t'(cfg_index);

	// Clamp the written width to 3..MAX_WIDTH and keep the last column index
	always_comb begin
		if (cfg_data < 11'd3) begin
			w_new = CB'(2);
		end else if (32'(cfg_data) > MAX_WIDTH) begin
			w_new = CB'(MAX_WIDTH - 1);
		end else begin
			w_new = CB'(cfg_data - 11'd1);
		end
	end

	// Clamp the written height to 3..MAX_HEIGHT and keep the last row index
	always_comb begin
		if (cfg_data < 11'd3) begin
			h_new = RB'(2);
		end else if (32'(cfg_data) > MAX_HEIGHT) begin
			h_new = RB'(MAX_HEIGHT - 1);
		end else begin
			h_new = RB'(cfg_data - 11'd1);
		end
	end

	// Geometry registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= CB'(W_RST - 1);
			h_last_q <= RB'(H_RST - 1);
		end else if (cfg_we) begin
			case (reg_sel)
				lsh_pkg::REG_IMAGE_WIDTH:  w_last_q <= w_new;
				lsh_pkg::REG_IMAGE_HEIGHT: h_last_q <= h_new;
				default: ;
			endcase
		end
	end

	// Advance the scan position per accepted pixel; restart on any write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (col_q == w_last_q) begin
				col_q <= '0;
				if (row_q == h_last_q) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + RB'(1);
				end
			end else begin
				col_q <= col_q + CB'(1);
			end
		end
	end

	assign col    = col_q;
	assign row    = row_q;
	assign w_last = w_last_q;
	assign h_last = h_last_q;

endmodule

// ----- design/lsh_kernel.sv -----
// 3x3 window registers and the saturated Laplacian sharpening arithmetic.
module lsh_kernel (
	input  logic               clk,
	input  logic               arst_n,
	input  lsh_pkg::win_ctrl_t ctrl,
	input  lsh_pkg::pix_t      pix,
	input  lsh_pkg::pix_t      top,
	input  lsh_pkg::pix_t      mid,
	output lsh_pkg::pix_t      sharp
);

	lsh_pkg::pix_t top1_q;
	lsh_pkg::pix_t mid1_q;
	lsh_pkg::pix_t mid2_q;
	lsh_pkg::pix_t bot1_q;

	logic [10:0]        five_c;
	logic [9:0]         neigh;
	logic signed [11:0] diff;

	// Shift the window one column on each advancing pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top1_q <= '0;
			mid1_q <= '0;
			mid2_q <= '0;
			bot1_q <= '0;
		end else if (ctrl.restart) begin
			top1_q <= '0;
			mid1_q <= '0;
			mid2_q <= '0;
			bot1_q <= '0;
		end else if (ctrl.advance) begin
			top1_q <= top;
			mid1_q <= mid;
			mid2_q <= mid1_q;
			bot1_q <= pix;
		end
	end

	// Five times the centre minus north, south, west and east
	always_comb begin
		five_c = {1'b0, mid1_q, 2'b00} + {3'b000, mid1_q};
		neigh  = {2'b00, top1_q} + {2'b00, bot1_q} + {2'b00, mid2_q} + {2'b00, mid};
		diff   = $signed({1'b0, five_c}) - $signed({2'b00, neigh});
	end

	// Saturate to the pixel range
	always_comb begin
		if (diff[11]) begin
			sharp = '0;
		end else if (diff[10:8] != 3'b000) begin
			sharp = '1;
		end else begin
			sharp = diff[7:0];
		end
	end

endmodule

// ----- design/laplacian_sharpen_3x3_unit.sv -----
// Top level of the streaming 3x3 Laplacian sharpening unit.
// Takes one grayscale pixel per clock in raster order while in_ready is high and returns,
// for each interior pixel, 5*centre minus its four direct neighbours saturated to 0..255,
// with its row and column and a flag on the last interior pixel of the frame. out_valid is
// set as stage 1 passes the pixel below and to the right of its centre into the output
// register; border pixels give no result. The rate is one pixel per clock while the output
// is not stalled, set by the single combined line store (one read and one write port), which
// holds the two previous rows and is read at the arriving pixel's column. While a result
// waits, one more pixel is held in the input stage before in_ready drops. Each write of
// image_width or image_height restarts the frame; write them only while the unit is idle.
module laplacian_sharpen_3x3_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  lsh_pkg::pix_t                 pixel,
	output logic                          out_valid,
	input  logic                          out_ready,
	output lsh_pkg::pix_t                 sharp_value,
	output lsh_pkg::out_idx_t             out_row,
	output lsh_pkg::out_idx_t             out_col,
	output logic                          frame_end,
	input  logic                          cfg_we,
	input  logic [lsh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  lsh_pkg::cfg_data_t            cfg_data
);

	localparam int CB    = $clog2(MAX_WIDTH);
	localparam int RB    = $clog2(MAX_HEIGHT);
	localparam int LINE_W = 2 * lsh_pkg::PIX_W;

	logic          in_accept;
	logic [CB-1:0] col;
	logic [RB-1:0] row;
	logic [CB-1:0] w_last;
	logic [RB-1:0] h_last;

	logic          s1_valid_q;
	lsh_pkg::pix_t pix_s1;
	logic [CB-1:0] col_s1;
	logic [RB-1:0] row_s1;
	logic          s1_adv;
	logic          s1_emit;
	logic [CB-1:0] col_m1;
	logic [RB-1:0] row_m1;

	logic [LINE_W-1:0] line_rd;
	lsh_pkg::pix_t     top_rd;
	lsh_pkg::pix_t     mid_rd;
	lsh_pkg::pix_t     sharp;
	lsh_pkg::win_ctrl_t win_ctrl;

	logic              out_valid_q;
	lsh_pkg::pix_t     sharp_q;
	lsh_pkg::out_idx_t out_row_q;
	lsh_pkg::out_idx_t out_col_q;
	logic              frame_end_q;

	// Handshake: stage 1 moves on whenever the output register is free or drains
	assign s1_adv    = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready  = !s1_valid_q || s1_adv;
	assign in_accept = in_valid && in_ready;

	lsh_scan #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (in_accept),
		.col       (col),
		.row       (row),
		.w_last    (w_last),
		.h_last    (h_last)
	);

	// Line store: upper row in the high byte, middle row in the low byte
	lsh_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (col_s1),
		.wdata ({mid_rd, pix_s1}),
		.re    (in_accept),
		.raddr (col),
		.rdata (line_rd)
	);

	assign top_rd = line_rd[LINE_W-1:lsh_pkg::PIX_W];
	assign mid_rd = line_rd[lsh_pkg::PIX_W-1:0];

	// Stage 1: hold the accepted pixel and its position while the line store reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			pix_s1 <= pixel;
			col_s1 <= col;
			row_s1 <= row;
		end
	end

	assign win_ctrl.advance = s1_adv;
	assign win_ctrl.restart = cfg_we;

	lsh_kernel u_kernel (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (win_ctrl),
		.pix    (pix_s1),
		.top    (top_rd),
		.mid    (mid_rd),
		.sharp  (sharp)
	);

	// Interior result exists once three rows and three columns have arrived
	assign s1_emit = (row_s1 >= RB'(2)) && (col_s1 >= CB'(2));
	assign col_m1  = col_s1 - CB'(1);
	assign row_m1  = row_s1 - RB'(1);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_emit) begin
			sharp_q     <= sharp;
			out_row_q   <= lsh_pkg::OUT_IDX_W'(row_m1);
			out_col_q   <= lsh_pkg::OUT_IDX_W'(col_m1);
			frame_end_q <= (row_s1 == h_last) && (col_s1 == w_last);
		end
	end

	assign out_valid   = out_valid_q;
	assign sharp_value = sharp_q;
	assign out_row     = out_row_q;
	assign out_col     = out_col_q;
	assign frame_end   = frame_end_q;

endmodule

// ----- design/lsh_checker.sv -----
// Port-level checks for the sharpening unit, bound to the top level.
module lsh_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input lsh_pkg::pix_t     sharp_value,
	input lsh_pkg::out_idx_t out_row,
	input lsh_pkg::out_idx_t out_col,
	input logic              frame_end
);

	// Hold a stalled result transaction unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sharp_value) && $stable(out_row)
			&& $stable(out_col) && $stable(frame_end))
		else $error("result changed while stalled");

	// Never report a position on the first row or the first column
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_row != '0) && (out_col != '0))
		else $error("result on a border row or column");

	// Take input whenever the output side is empty
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output");

	// A fresh result follows an earlier input transaction
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching input transaction");

endmodule

bind laplacian_sharpen_3x3_unit lsh_checker u_lsh_checker (.*);

// ----- tb/sv/tb_laplacian_sharpen_3x3_unit.sv -----
// Self-checking testbench for the streaming 3x3 Laplacian sharpening unit.
`timescale 1ns / 1ps

module tb_laplacian_sharpen_3x3_unit;

	localparam int HALF_PERIOD    = 2;
	localparam int RESET_CYCLES   = 10;
	localparam int MAX_W          = 1024;
	localparam int MAX_H          = 1024;
	localparam int CENTRE_GAIN    = 5;
	localparam int SETTLE_CYCLES  = 12;
	localparam int WATCHDOG_LIMIT = 500;
	localparam int RANDOM_PHASES  = 6;
	localparam int RESET_PIXELS   = 60;
	localparam int EXTREME_PIXELS = 150;
	localparam int TALL_ROWS      = 50;

	typedef struct packed {
		lsh_pkg::pix_t     value;
		lsh_pkg::out_idx_t row;
		lsh_pkg::out_idx_t col;
		logic              last;
	} sharp_result_t;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_ready;
	lsh_pkg::pix_t      pixel      = '0;
	logic               out_valid;
	logic               out_ready  = 1'b0;
	lsh_pkg::pix_t      sharp_value;
	lsh_pkg::out_idx_t  out_row;
	lsh_pkg::out_idx_t  out_col;
	logic               frame_end;
	logic               cfg_we     = 1'b0;
	logic [lsh_pkg::CFG_IDX_W-1:0] cfg_index = lsh_pkg::REG_IMAGE_WIDTH;
	lsh_pkg::cfg_data_t cfg_data   = '0;

	// Stimulus and expectation stores
	lsh_pkg::pix_t pixel_feed_q[$];
	sharp_result_t sharp_expect_q[$];

	// Mirror of the unit: geometry registers, line stores, window, raster position
	lsh_pkg::cfg_data_t geom_w = lsh_pkg::cfg_data_t'(MAX_W);
	lsh_pkg::cfg_data_t geom_h = lsh_pkg::cfg_data_t'(MAX_H);
	lsh_pkg::pix_t      upper_row [MAX_W];
	lsh_pkg::pix_t      middle_row [MAX_W];
	lsh_pkg::pix_t      top_c1 = '0;
	lsh_pkg::pix_t      mid_c1 = '0;
	lsh_pkg::pix_t      mid_c2 = '0;
	lsh_pkg::pix_t      bot_c1 = '0;
	int                 row_pos = 0;
	int                 col_pos = 0;

	// Handshake bookkeeping and run statistics
	bit in_taken     = 1'b0;
	bit out_taken    = 1'b0;
	bit idle_on      = 1'b1;
	int send_gap     = 0;
	int recv_stall   = 0;
	int stall_cycles = 0;
	int mismatch_count = 0;
	int pixels_in    = 0;
	int results_out  = 0;
	int frame_ends   = 0;
	int reg_writes   = 0;

	laplacian_sharpen_3x3_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel       (pixel),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sharp_value (sharp_value),
		.out_row     (out_row),
		.out_col     (out_col),
		.frame_end   (frame_end),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Effective frame dimension: small values act as 3, large ones as the maximum
	function automatic int dim_eff(input lsh_pkg::cfg_data_t raw, input int limit);
		if (raw < 3)
			return 3;
		if (raw > limit)
			return limit;
		return int'(raw);
	endfunction

	// Advance the mirror by one pixel and queue the sharpened result it completes
	function automatic void predict_sharp(input lsh_pkg::pix_t pix);
		int            w;
		int            h;
		int            acc;
		lsh_pkg::pix_t above;
		lsh_pkg::pix_t level;
		sharp_result_t r;
		w = dim_eff(geom_w, MAX_W);
		h = dim_eff(geom_h, MAX_H);
		if (col_pos >= w || row_pos >= h) begin
			col_pos = 0;
			row_pos = 0;
		end
		above = upper_row[col_pos];
		level = middle_row[col_pos];
		upper_row[col_pos]  = level;
		middle_row[col_pos] = pix;
		// centre sits one row up and one column left; level is its east neighbour
		if (row_pos >= 2 && col_pos >= 2) begin
			acc = CENTRE_GAIN * int'(mid_c1) - int'(top_c1) - int'(bot_c1)
				- int'(mid_c2) - int'(level);
			if (acc < 0)
				r.value = '0;
			else if (acc > 255)
				r.value = '1;
			else
				r.value = lsh_pkg::pix_t'(acc);
			r.row  = lsh_pkg::out_idx_t'(row_pos - 1);
			r.col  = lsh_pkg::out_idx_t'(col_pos - 1);
			r.last = (row_pos == h - 1) && (col_pos == w - 1);
			sharp_expect_q.push_back(r);
		end
		top_c1 = above;
		mid_c2 = mid_c1;
		mid_c1 = level;
		bot_c1 = pix;
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h)
				row_pos = 0;
		end
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Write one geometry register while idle; the frame restarts in the mirror too
	task automatic write_reg(input lsh_pkg::cfg_reg_t idx, input lsh_pkg::cfg_data_t val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == lsh_pkg::REG_IMAGE_WIDTH)
			geom_w = val;
		else
			geom_h = val;
		row_pos = 0;
		col_pos = 0;
		top_c1  = '0;
		mid_c1  = '0;
		mid_c2  = '0;
		bot_c1  = '0;
		reg_writes++;
	endtask

	// Queue random pixels, biased toward black and white to hit both clip limits
	task automatic feed_pixels(input int count);
		repeat (count) begin
			if ($urandom_range(0, 3) == 0)
				pixel_feed_q.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
			else
				pixel_feed_q.push_back(lsh_pkg::pix_t'($urandom_range(0, 255)));
		end
	endtask

	// Hold until every pixel is taken and every result is back, then let the pipe settle
	task automatic wait_idle(input int settle);
		do begin
			@(posedge clk);
			#1;
		end while (pixel_feed_q.size() != 0 || in_valid || sharp_expect_q.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	// Pixel driver: hold while a transaction waits, otherwise issue or insert a gap
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (pixel_feed_q.size() != 0) begin
				in_valid <= 1'b1;
				pixel    <= pixel_feed_q.pop_front();
				if (idle_on && $urandom_range(0, 9) == 0)
					send_gap = $urandom_range(1, 14);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: stall in random bursts while idle_on is set
	always @(negedge clk) begin
		if (recv_stall > 0) begin
			out_ready <= 1'b0;
			recv_stall--;
		end else begin
			out_ready <= 1'b1;
			if (idle_on && $urandom_range(0, 11) == 0)
				recv_stall = $urandom_range(1, 14);
		end
	end

	// Monitor: predict on accepted pixels, check accepted results, run the watchdog
	always @(posedge clk) begin : monitor
		sharp_result_t want;
		in_taken  = arst_n && in_valid && in_ready;
		out_taken = arst_n && out_valid && out_ready;
		if (in_taken) begin
			pixels_in++;
			predict_sharp(pixel);
		end
		if (out_taken) begin
			results_out++;
			if (frame_end)
				frame_ends++;
			if (sharp_expect_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result value %0d row %0d col %0d",
					sharp_value, out_row, out_col));
			end else begin
				want = sharp_expect_q.pop_front();
				if (sharp_value !== want.value)
					report_mismatch($sformatf("sharp_value %0d, want %0d at row %0d col %0d",
						sharp_value, want.value, want.row, want.col));
				if (out_row !== want.row)
					report_mismatch($sformatf("out_row %0d, want %0d", out_row, want.row));
				if (out_col !== want.col)
					report_mismatch($sformatf("out_col %0d, want %0d at row %0d",
						out_col, want.col, want.row));
				if (frame_end !== want.last)
					report_mismatch($sformatf("frame_end %b, want %b at row %0d col %0d",
						frame_end, want.last, want.row, want.col));
			end
		end
		// Drop out when no transaction moves for too long
		if (in_taken || out_taken) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
					stall_cycles, sharp_expect_q.size());
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Stimulus sequence
	initial begin : stimulus
		int fw;
		int fh;
		int split;
		int wrote;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Reset geometry: the start of the first 1024-wide row gives no result
		feed_pixels(RESET_PIXELS);
		wait_idle(SETTLE_CYCLES);

		// Smallest frame, two back to back: bright dot clips high, dark dot clips low
		write_reg(lsh_pkg::REG_IMAGE_WIDTH, lsh_pkg::cfg_data_t'(3));
		write_reg(lsh_pkg::REG_IMAGE_HEIGHT, lsh_pkg::cfg_data_t'(3));
		for (int i = 0; i < 9; i++)
			pixel_feed_q.push_back((i == 4) ? 8'hFF : 8'h00);
		for (int i = 0; i < 9; i++)
			pixel_feed_q.push_back((i == 4) ? 8'h00 : 8'hFF);
		wait_idle(SETTLE_CYCLES);

		// Undersized registers act as 3; pause the sender mid-frame until drained
		write_reg(lsh_pkg::REG_IMAGE_WIDTH, lsh_pkg::cfg_data_t'(1));
		write_reg(lsh_pkg::REG_IMAGE_HEIGHT, lsh_pkg::cfg_data_t'(2));
		feed_pixels(5);
		wait_idle(0);
		feed_pixels(4);
		wait_idle(SETTLE_CYCLES);

		// Random small geometries with whole, split and truncated frames
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			idle_on = ($urandom_range(0, 3) != 0);
			wrote = 0;
			if ($urandom_range(0, 3) != 0) begin
				write_reg(lsh_pkg::REG_IMAGE_WIDTH,
					lsh_pkg::cfg_data_t'(($urandom_range(0, 7) == 0) ?
					$urandom_range(0, 2) : $urandom_range(3, 10)));
				wrote = 1;
			end
			if ($urandom_range(0, 3) != 0 || wrote == 0)
				write_reg(lsh_pkg::REG_IMAGE_HEIGHT,
					lsh_pkg::cfg_data_t'(($urandom_range(0, 7) == 0) ?
					$urandom_range(0, 2) : $urandom_range(3, 8)));
			fw = dim_eff(geom_w, MAX_W);
			fh = dim_eff(geom_h, MAX_H);
			repeat ($urandom_range(1, 2)) begin
				if ($urandom_range(0, 5) == 0) begin
					split = $urandom_range(1, fw * fh - 1);
					feed_pixels(split);
					wait_idle(0);
					feed_pixels(fw * fh - split);
				end else begin
					feed_pixels(fw * fh);
				end
			end
			// Leave a frame unfinished; the next register write restarts it
			if ($urandom_range(0, 2) == 0)
				feed_pixels($urandom_range(1, fw * fh - 1));
			wait_idle(SETTLE_CYCLES);
		end

		// Extremes: widest row, tall frame, oversized and zero registers
		idle_on = 1'b1;
		write_reg(lsh_pkg::REG_IMAGE_WIDTH, lsh_pkg::cfg_data_t'(MAX_W));
		write_reg(lsh_pkg::REG_IMAGE_HEIGHT, lsh_pkg::cfg_data_t'(3));
		feed_pixels(EXTREME_PIXELS);
		wait_idle(SETTLE_CYCLES);
		write_reg(lsh_pkg::REG_IMAGE_WIDTH, lsh_pkg::cfg_data_t'(3));
		write_reg(lsh_pkg::REG_IMAGE_HEIGHT, '1);
		feed_pixels(3 * TALL_ROWS);
		wait_idle(SETTLE_CYCLES);
		write_reg(lsh_pkg::REG_IMAGE_WIDTH, '1);
		write_reg(lsh_pkg::REG_IMAGE_HEIGHT, '0);
		feed_pixels(EXTREME_PIXELS);
		wait_idle(SETTLE_CYCLES);

		// Closing stretch at full rate on both sides
		idle_on = 1'b0;
		write_reg(lsh_pkg::REG_IMAGE_WIDTH, lsh_pkg::cfg_data_t'($urandom_range(3, 10)));
		write_reg(lsh_pkg::REG_IMAGE_HEIGHT, lsh_pkg::cfg_data_t'($urandom_range(3, 8)));
		feed_pixels(2 * dim_eff(geom_w, MAX_W) * dim_eff(geom_h, MAX_H));
		wait_idle(SETTLE_CYCLES);

		$display("run covered %0d pixels and %0d sharpened results over %0d frame ends,",
			pixels_in, results_out, frame_ends);
		$display("with %0d geometry register writes from 0 to 2047; %0d mismatches",
			reg_writes, mismatch_count);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
